>>> rtl/core/abs_diff_integral_image_top_assert.svh
// Assertion macros for the checker file.
`ifndef ABS_DIFF_INTEGRAL_IMAGE_TOP_ASSERT_SVH
`define ABS_DIFF_INTEGRAL_IMAGE_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define ADII_ASSERT_SAME(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define ADII_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ADII_ASSERT_RESET(lbl, pre, post) \
   lbl: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

>>> rtl/core/adii_pkg.sv
package adii_pkg;

   localparam int SUM_W          = 32;
   localparam int SAMPLE_W       = 16;
   localparam int CSR_W          = 9;
   localparam int SIDE_RESET_VAL = 64;

   // Accept-stage payload handed to the accumulate stage.
   typedef struct packed {
      logic [SUM_W-1:0] row_sum;
      logic             first_row;
      logic             last_col;
      logic             last_row;
   } stage_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
   endfunction

endpackage

>>> rtl/core/adii_ram.sv
module adii_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/adii_front.sv
module adii_front
   import adii_pkg::*;
#(
   parameter int MAX_SIDE    = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [CSR_W-1:0]             csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [SAMPLE_W-1:0]          req_sample_n,
   input  logic [SAMPLE_W-1:0]          req_sample_m,
   input  logic                         out_free,
   output logic                         accept,
   output logic [$clog2(MAX_SIDE)-1:0]  rd_col,
   output logic                         s1_valid,
   output logic [$clog2(MAX_SIDE)-1:0]  s1_col,
   output stage_type                    s1_data
);

   localparam int CNT_W    = $clog2(MAX_SIDE);
   localparam int SW       = CNT_W + 1;
   localparam int EFF_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam logic [SW-1:0] SIDE_RESET =
      (SIDE_RESET_VAL > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(SIDE_RESET_VAL);

   logic [SW-1:0]    side_ff;
   logic [SW-1:0]    side_clamped;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [SUM_W-1:0] row_sum_ff, row_sum_in;
   logic [SUM_W-1:0] row_sum_next;
   logic             s1_valid_ff, s1_valid_in;
   logic [CNT_W-1:0] s1_col_ff;
   stage_type        s1_data_ff, s1_data_in;
   logic [EFF_BITS-1:0] a, b, diff;
   logic             last_col, last_row;

   // clamp the written side length into 1 .. MAX_SIDE
   always_comb begin
      if (csr_wr_data == '0) begin
         side_clamped = SW'(1);
      end else if (32'(csr_wr_data) > 32'(MAX_SIDE)) begin
         side_clamped = SW'(MAX_SIDE);
      end else begin
         side_clamped = SW'(csr_wr_data);
      end
   end

   assign req_stall = s1_valid_ff & ~out_free;
   assign accept    = req_valid & ~req_stall;

   assign a    = req_sample_n[EFF_BITS-1:0];
   assign b    = req_sample_m[EFF_BITS-1:0];
   assign diff = (a >= b) ? (a - b) : (b - a);

   assign last_col = ((SW'(col_ff) + SW'(1)) == side_ff);
   assign last_row = ((SW'(row_ff) + SW'(1)) == side_ff);

   assign row_sum_next = sat_add(row_sum_ff, SUM_W'(diff));

   always_comb begin
      col_in     = last_col ? '0 : col_ff + CNT_W'(1);
      row_in     = row_ff;
      row_sum_in = last_col ? '0 : row_sum_next;
      if (last_col) begin
         row_in = last_row ? '0 : row_ff + CNT_W'(1);
      end
      s1_data_in.row_sum   = row_sum_next;
      s1_data_in.first_row = (row_ff == '0);
      s1_data_in.last_col  = last_col;
      s1_data_in.last_row  = last_row;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff     <= SIDE_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         row_sum_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_wr_en) begin
            // restart the image on every side length write
            side_ff    <= side_clamped;
            col_ff     <= '0;
            row_ff     <= '0;
            row_sum_ff <= '0;
         end else if (accept) begin
            col_ff     <= col_in;
            row_ff     <= row_in;
            row_sum_ff <= row_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= col_ff;
         s1_data_ff <= s1_data_in;
      end
   end

   assign rd_col   = col_ff;
   assign s1_valid = s1_valid_ff;
   assign s1_col   = s1_col_ff;
   assign s1_data  = s1_data_ff;

endmodule

>>> rtl/core/adii_back.sv
module adii_back
   import adii_pkg::*;
#(
   parameter int MAX_SIDE = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [$clog2(MAX_SIDE)-1:0]  rd_col,
   input  logic                         s1_valid,
   input  logic [$clog2(MAX_SIDE)-1:0]  s1_col,
   input  stage_type                    s1_data,
   input  logic                         rsp_stall,
   output logic                         out_free,
   output logic                         rsp_valid,
   output logic [SUM_W-1:0]             rsp_integral_value,
   output logic                         rsp_row_end,
   output logic                         rsp_image_end
);

   localparam int CNT_W = $clog2(MAX_SIDE);

   logic             s1_fire;
   logic [SUM_W-1:0] ram_rdata;
   logic [SUM_W-1:0] above;
   logic [SUM_W-1:0] value;
   logic             byp_hit;
   logic             byp_ff;
   logic [SUM_W-1:0] byp_data_ff;
   logic             rsp_valid_ff;
   logic [SUM_W-1:0] value_ff;
   logic             row_end_ff, image_end_ff;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign s1_fire  = s1_valid & out_free;

   // a read issued while the previous pixel of the same column is written
   // (side of one) takes the written value instead of the stale entry
   assign byp_hit = s1_fire && (s1_col == rd_col);

   assign above = s1_data.first_row ? '0 : (byp_ff ? byp_data_ff : ram_rdata);
   assign value = sat_add(above, s1_data.row_sum);

   adii_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_SIDE)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col),
      .wr_data (value),
      .rd_en   (accept),
      .rd_addr (rd_col[CNT_W-1:0]),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            byp_ff <= byp_hit;
         end
         rsp_valid_ff <= s1_fire | (rsp_valid_ff & rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byp_data_ff <= value;
      end
      if (s1_fire) begin
         value_ff     <= value;
         row_end_ff   <= s1_data.last_col;
         image_end_ff <= s1_data.last_col & s1_data.last_row;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_integral_value = value_ff;
   assign rsp_row_end        = row_end_ff;
   assign rsp_image_end      = image_end_ff;

endmodule

>>> rtl/core/abs_diff_integral_image_top.sv
// Pipeline: a taken transaction passes the accept register, then the result
// register, before rsp_valid rises.
// Throughput: one pixel pair per cycle while no result waits on rsp_stall,
// set by one line buffer read and write per pixel and the one accumulate add.
// Reset: synchronous, active high; side length returns to 64 and the next
// transaction is pixel (0,0). The line buffer is not cleared.
module abs_diff_integral_image_top
   import adii_pkg::*;
#(
   parameter int MAX_SIDE    = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   // side length register
   input  logic                csr_wr_en,
   input  logic [CSR_W-1:0]    csr_wr_data,
   // pixel pair transactions
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample_n,
   input  logic [SAMPLE_W-1:0] req_sample_m,
   // integral value transactions
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SUM_W-1:0]    rsp_integral_value,
   output logic                rsp_row_end,
   output logic                rsp_image_end
);

   localparam int CNT_W = $clog2(MAX_SIDE);

   logic             out_free;
   logic             accept;
   logic [CNT_W-1:0] rd_col;
   logic             s1_valid;
   logic [CNT_W-1:0] s1_col;
   stage_type        s1_data;

   // Accept stage: hold the side length, advance the column and row counters,
   // form |n - m| and add it into the running row sum. The line buffer read
   // for the same column is launched in this cycle.
   adii_front #(
      .MAX_SIDE    (MAX_SIDE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_n (req_sample_n),
      .req_sample_m (req_sample_m),
      .out_free     (out_free),
      .accept       (accept),
      .rd_col       (rd_col),
      .s1_valid     (s1_valid),
      .s1_col       (s1_col),
      .s1_data      (s1_data)
   );

   // Accumulate stage: add the value one row above (zero on the first row),
   // write it back to the line buffer and load the result register. The
   // result register parts the two sides, so a new transaction is taken while
   // a finished one waits on rsp_stall, as long as the accept stage is empty.
   adii_back #(
      .MAX_SIDE (MAX_SIDE)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .rd_col             (rd_col),
      .s1_valid           (s1_valid),
      .s1_col             (s1_col),
      .s1_data            (s1_data),
      .rsp_stall          (rsp_stall),
      .out_free           (out_free),
      .rsp_valid          (rsp_valid),
      .rsp_integral_value (rsp_integral_value),
      .rsp_row_end        (rsp_row_end),
      .rsp_image_end      (rsp_image_end)
   );

endmodule

>>> rtl/core/adii_checker.sv
`include "abs_diff_integral_image_top_assert.svh"

module adii_checker
   import adii_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [SUM_W-1:0] rsp_integral_value,
   input logic             rsp_row_end,
   input logic             rsp_image_end
);

   logic [SUM_W+1:0] rsp_payload;

   assign rsp_payload = {rsp_integral_value, rsp_row_end, rsp_image_end};

   `ADII_ASSERT_RESET(a_reset_clears_rsp, reset, !rsp_valid)
   `ADII_ASSERT_SAME(a_stall_needs_full_out, req_stall, rsp_valid && rsp_stall)
   `ADII_ASSERT_SAME(a_image_end_is_row_end, rsp_valid && rsp_image_end, rsp_row_end)
   `ADII_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `ADII_ASSERT_NEXT(a_req_taken_shows, req_valid && !req_stall, ##1 rsp_valid)

endmodule

bind abs_diff_integral_image_top adii_checker u_checker (.*);

>>> bench/abs_diff_integral_image_top_test.sv
module abs_diff_integral_image_top_test;
   import adii_pkg::*;

   // Block geometry and run limits.
   localparam int MAX_SIDE     = 256;
   localparam int PIPE_LATENCY = 2;      // accept register, then result register
   localparam int STALL_LIMIT  = 1000;   // cycles with no transaction before giving up
   localparam int PIXEL_TARGET = 1250;   // stop opening random phases past this
   localparam int MAX_REPORTS  = 10;

   // One predicted result transaction.
   typedef struct packed {
      logic [SUM_W-1:0] integral;
      logic             row_end;
      logic             image_end;
   } sum_entry_type;

   // Scoreboard: tracks the summed-area table of |n - m| for the current image
   // and holds the predicted integral values in transaction order.
   class integral_board_type;
      logic [CSR_W-1:0] side_reg;
      logic [SUM_W-1:0] row_sum;
      logic [SUM_W-1:0] line_buf [MAX_SIDE];
      int unsigned      col_pos;
      int unsigned      row_pos;
      sum_entry_type    expected_sums [$];
      int unsigned      mismatches;

      function new();
         side_reg    = CSR_W'(SIDE_RESET_VAL);
         mismatches  = 0;
         foreach (line_buf[i]) line_buf[i] = '0;
         restart();
      endfunction

      function void restart();
         row_sum = '0;
         col_pos = 0;
         row_pos = 0;
      endfunction

      // A side of 0 behaves as 1, anything above the buffer depth as the depth.
      function int unsigned active_side();
         if (side_reg == 0) return 1;
         if (side_reg > MAX_SIDE) return MAX_SIDE;
         return side_reg;
      endfunction

      function logic [SUM_W-1:0] add_clamped(logic [SUM_W-1:0] x, logic [SUM_W-1:0] y);
         if (x > ({SUM_W{1'b1}} - y)) return {SUM_W{1'b1}};
         return x + y;
      endfunction

      // A register write also restarts the image at pixel (0,0).
      function void set_side(logic [CSR_W-1:0] v);
         side_reg = v;
         restart();
      endfunction

      // Predict the integral value for one accepted pixel pair.
      function void take_pixel_pair(logic [SAMPLE_W-1:0] n, logic [SAMPLE_W-1:0] m);
         logic [SUM_W-1:0] a, b, diff, above;
         int unsigned      side;
         sum_entry_type    e;
         a    = n;
         b    = m;
         diff = (a >= b) ? a - b : b - a;
         side = active_side();
         if (col_pos >= side) col_pos = 0;
         if (row_pos >= side) row_pos = 0;
         row_sum           = add_clamped(row_sum, diff);
         above             = (row_pos == 0) ? '0 : line_buf[col_pos];
         e.integral        = add_clamped(above, row_sum);
         line_buf[col_pos] = e.integral;
         e.row_end         = (col_pos + 1 == side);
         e.image_end       = e.row_end && (row_pos + 1 == side);
         expected_sums.insert(expected_sums.size(), e);
         if (e.row_end) begin
            col_pos = 0;
            row_sum = '0;
            row_pos = e.image_end ? 0 : row_pos + 1;
         end else begin
            col_pos = col_pos + 1;
         end
      endfunction

      // Compare one accepted result with the oldest prediction.
      function void match_result(logic [SUM_W-1:0] value, logic row_end, logic image_end);
         sum_entry_type want;
         if (expected_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result with nothing predicted: value %0d row_end %0b image_end %0b",
                        $realtime, value, row_end, image_end);
            return;
         end
         want = expected_sums.pop_front();
         if (value !== want.integral || row_end !== want.row_end
             || image_end !== want.image_end) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: integral mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                        $realtime, want.integral, want.row_end, want.image_end,
                        value, row_end, image_end);
         end
      endfunction

      function int unsigned pending();
         return expected_sums.size();
      endfunction
   endclass

   // Everything the block sees is known from time zero.
   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                csr_wr_en    = 1'b0;
   logic [CSR_W-1:0]    csr_wr_data  = '0;
   logic                req_valid    = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample_n = '0;
   logic [SAMPLE_W-1:0] req_sample_m = '0;
   logic                rsp_valid;
   logic                rsp_stall    = 1'b0;
   logic [SUM_W-1:0]    rsp_integral_value;
   logic                rsp_row_end;
   logic                rsp_image_end;

   integral_board_type board;
   bit            idle_on      = 1'b0;   // random gaps on both sides when set
   int            rsp_hold_req = 0;      // long receiver hold-off, picked up by the sink
   int unsigned   pixels_sent  = 0;

   always #5 clock = ~clock;

   abs_diff_integral_image_top DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_n       (req_sample_n),
      .req_sample_m       (req_sample_m),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_integral_value (rsp_integral_value),
      .rsp_row_end        (rsp_row_end),
      .rsp_image_end      (rsp_image_end)
   );

   // Offer one pixel pair and hold it until the block takes it. Returns in the
   // time step of the accepting edge with valid still high, so a back-to-back
   // transaction keeps valid up without a glitch.
   task automatic send_pixel(input logic [SAMPLE_W-1:0] n, input logic [SAMPLE_W-1:0] m);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_sample_n <= n;
      req_sample_m <= m;
      do @(posedge clock); while (req_stall);
      board.take_pixel_pair(n, m);
      pixels_sent++;
   endtask

   // Drop valid and hold the sender until every predicted result has come back.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Drain, then let the pipeline empty out before touching the register.
   task automatic settle();
      pause_until_drained();
      repeat (PIPE_LATENCY + 1) @(posedge clock);
   endtask

   // One write of the side-length register; the block restarts its image.
   task automatic write_side(input logic [CSR_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_side(v);
   endtask

   // Result sink: stall for a random number of cycles per transaction, or for
   // a long stretch when asked, then take the next result and check it.
   initial begin : result_sink
      int w;
      wait (reset == 1'b0);
      forever begin
         if (rsp_hold_req > 0) begin
            w            = rsp_hold_req;
            rsp_hold_req = 0;
         end else begin
            w = idle_on ? $urandom_range(0, 3) : 0;
         end
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         board.match_result(rsp_integral_value, rsp_row_end, rsp_image_end);
      end
   end

   // Watchdog: end the run if no transaction moves on either channel for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      logic [CSR_W-1:0]    side;
      logic [SAMPLE_W-1:0] pn, pm;
      int                  eff, length, pause_at, big_left, images, i;
      bit                  hold_done, extremes;

      board     = new();
      big_left  = 3;
      hold_done = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset side of 64, corner values of both samples, no idling.
      idle_on = 1'b0;
      send_pixel(16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'h0000);
      send_pixel(16'h0000, 16'hFFFF);
      send_pixel(16'hFFFF, 16'hFFFF);
      send_pixel(16'h8000, 16'h7FFF);
      send_pixel(16'h0001, 16'h0000);
      send_pixel(16'h0000, 16'h0001);
      send_pixel(16'hAAAA, 16'h5555);
      send_pixel(16'h5555, 16'hAAAA);
      settle();

      // Side of 0 behaves as 1: every pixel ends its row and its image.
      write_side('0);
      send_pixel(16'hFFFF, 16'h0000);
      send_pixel(16'h0000, 16'hFFFF);
      send_pixel(16'h0001, 16'h0002);
      settle();

      // Side 2: run past the end of one image into the next.
      write_side(CSR_W'(2));
      send_pixel(16'hFFFF, 16'h0000);
      send_pixel(16'h1234, 16'h4321);
      send_pixel(16'h0000, 16'hFFFF);
      send_pixel(16'hFFFF, 16'hFFFE);
      send_pixel(16'h00FF, 16'hFF00);
      settle();

      // Same side again mid-image: the write alone must restart at (0,0).
      write_side(CSR_W'(2));
      send_pixel(16'h7FFF, 16'h8000);
      send_pixel(16'hFFFF, 16'h0000);
      send_pixel(16'h0000, 16'hFFFF);
      settle();

      // All register bits high: clamps to the buffer depth.
      write_side({CSR_W{1'b1}});
      send_pixel(16'hFFFF, 16'h0000);
      send_pixel(16'h0000, 16'hFFFF);
      settle();

      // Random phases: mostly complete small images, a few large or clamped
      // sides, and some phases cut short so the next write restarts mid-image.
      while (pixels_sent < PIXEL_TARGET) begin
         if ($urandom_range(0, 15) == 0 && big_left > 0) begin
            case ($urandom_range(0, 2))
               0: side = CSR_W'(MAX_SIDE);
               1: side = {CSR_W{1'b1}};
               default: side = CSR_W'($urandom_range(MAX_SIDE + 1, 510));
            endcase
            length = MAX_SIDE + $urandom_range(1, 48);
            big_left--;
         end else if ($urandom_range(0, 15) == 0) begin
            side   = '0;
            length = $urandom_range(2, 12);
         end else begin
            side   = CSR_W'($urandom_range(1, $urandom_range(0, 1) ? 4 : 16));
            images = (side <= 4) ? $urandom_range(1, 3) : 1;
            length = images * side * side;
            if ($urandom_range(0, 2) == 0) length += $urandom_range(1, side * side);
         end
         write_side(side);
         eff      = board.active_side();
         extremes = (eff >= MAX_SIDE) || ($urandom_range(0, 3) == 0);
         idle_on  = ($urandom_range(0, 3) != 0);
         pause_at = ($urandom_range(0, 3) == 0 && length > 1) ? $urandom_range(1, length - 1)
                                                              : -1;

         // Once, hold the sink off long enough that the block backs up and
         // stalls its input while the sender keeps offering.
         if (!hold_done && length >= 16) begin
            rsp_hold_req = 48;
            hold_done    = 1'b1;
         end

         for (i = 0; i < length; i++) begin
            if (i == pause_at) pause_until_drained();
            case ($urandom_range(0, extremes ? 2 : 7))
               0: begin pn = '1; pm = '0; end
               1: begin pn = '0; pm = '1; end
               2: begin pn = SAMPLE_W'($urandom_range(0, 65535)); pm = pn; end
               default: begin
                  pn = SAMPLE_W'($urandom_range(0, 65535));
                  pm = SAMPLE_W'($urandom_range(0, 65535));
               end
            endcase
            send_pixel(pn, pm);
         end
         settle();
      end

      // Wait out any stray late result before judging the run.
      idle_on = 1'b0;
      repeat (PIPE_LATENCY + 8) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/adii_pkg.sv
rtl/core/adii_ram.sv
rtl/core/adii_front.sv
rtl/core/adii_back.sv
rtl/core/abs_diff_integral_image_top.sv
rtl/core/adii_checker.sv
bench/abs_diff_integral_image_top_test.sv
